FILE: hdl/smb_pkg.sv
// Shared constants, types and the find-first helper of the slot message buffer.
package smb_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SIZE_W = 8;
  localparam int WORD_W = 64;
  localparam int OUT_SLOT_W = 6;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  typedef logic [SLOTS-1:0]      flags_t;
  typedef logic [SLOT_W-1:0]     slot_idx_t;
  typedef logic [OUT_SLOT_W-1:0] out_slot_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [WORD_W-1:0]     word_t;

  typedef struct packed {
    logic      any;
    slot_idx_t idx;
  } first_t;

  typedef struct packed {
    logic      wr_en;
    logic      clr_en;
    logic      last_set;
    logic      last_clr;
    slot_idx_t idx;
  } store_ctl_t;

  function automatic first_t first_set(flags_t flags);
    first_t res;
    res.any = 1'b0;
    res.idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (flags[i]) begin
        res.any = 1'b1;
        res.idx = slot_idx_t'(i);
      end
    end
    return res;
  endfunction

endpackage

FILE: hdl/smb_if.sv
// Request and result channel interfaces of the slot message buffer.
interface smb_in_if;
  import smb_pkg::*;
  logic  valid;
  logic  ready;
  logic  func;
  size_t msg_size;
  word_t msg_word;
  modport source(output valid, output func, output msg_size, output msg_word, input ready);
  modport sink(input valid, input func, input msg_size, input msg_word, output ready);
endinterface

interface smb_out_if;
  import smb_pkg::*;
  logic      valid;
  logic      ready;
  logic      found;
  out_slot_t slot;
  logic      overwrote;
  size_t     out_size;
  word_t     out_word;
  modport source(output valid, output found, output slot, output overwrote,
                 output out_size, output out_word, input ready);
  modport sink(input valid, input found, input slot, input overwrote,
               input out_size, input out_word, output ready);
endinterface

FILE: hdl/smb_scan.sv
// Slot selection for append and pop requests from the used flags and pop pointer.
module smb_scan (
  input  smb_pkg::flags_t    used,
  input  smb_pkg::slot_idx_t last_slot,
  input  logic               last_valid,
  input  logic               accept,
  input  logic               func,
  output smb_pkg::store_ctl_t ctl,
  output logic               found,
  output logic               overwrote
);
  import smb_pkg::*;

  first_t free_first;
  first_t last_first;
  first_t zero_first;
  flags_t masked;
  logic   is_pop;

  always_comb begin
    is_pop     = (func == FUNC_POP);
    free_first = first_set(~used);
    masked     = used & ({SLOTS{1'b1}} << last_slot);
    last_first = first_set(masked);
    zero_first = first_set(used);

    ctl = '0;
    if (is_pop) begin
      found     = zero_first.any;
      overwrote = 1'b0;
      if (last_valid && last_first.any) begin
        ctl.idx = last_first.idx;
      end else begin
        ctl.idx = zero_first.idx;
      end
      ctl.clr_en   = accept && found;
      ctl.last_set = accept && found;
      ctl.last_clr = accept && !found;
    end else begin
      found     = 1'b1;
      overwrote = !free_first.any;
      ctl.idx   = free_first.any ? free_first.idx : '0;
      ctl.wr_en = accept;
    end
  end

endmodule

FILE: hdl/smb_store.sv
// Slot storage: used flags, message contents and the last popped index.
module smb_store (
  input  logic                clk,
  input  logic                rst_n,
  input  smb_pkg::store_ctl_t ctl,
  input  smb_pkg::size_t      wr_size,
  input  smb_pkg::word_t      wr_word,
  output smb_pkg::flags_t     used,
  output smb_pkg::slot_idx_t  last_slot,
  output logic                last_valid,
  output smb_pkg::size_t      rd_size,
  output smb_pkg::word_t      rd_word
);
  import smb_pkg::*;

  flags_t    used_r;
  slot_idx_t last_slot_r;
  logic      last_valid_r;
  size_t     size_r [SLOTS];
  word_t     word_r [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      last_slot_r  <= '0;
      last_valid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        used_r[ctl.idx] <= 1'b1;
      end
      if (ctl.clr_en) begin
        used_r[ctl.idx] <= 1'b0;
      end
      if (ctl.last_set) begin
        last_slot_r  <= ctl.idx;
        last_valid_r <= 1'b1;
      end else if (ctl.last_clr) begin
        last_slot_r  <= '0;
        last_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      size_r[ctl.idx] <= wr_size;
      word_r[ctl.idx] <= wr_word;
    end
  end

  assign used       = used_r;
  assign last_slot  = last_slot_r;
  assign last_valid = last_valid_r;
  assign rd_size    = size_r[ctl.idx];
  assign rd_word    = word_r[ctl.idx];

endmodule

FILE: hdl/slot_message_buffer.sv
// Top level of the slot message buffer with the result register.
//
//  Channel   Dir  Contents
//  in_ch     in   func, msg_size, msg_word
//  out_ch    out  found, slot, overwrote, out_size, out_word
//
// Each request is decided by a combinational slot scan over the used flags, and its
// result is registered and the store written at the accept edge.
// A new request is taken every cycle while the result register is empty or
// being drained, so sustained throughput is one request per cycle.
// Reset clears all used flags and the pop pointer; contents are not cleared.
// A stalled result holds in the output register and blocks further requests.
module slot_message_buffer (
  input logic      clk,
  input logic      rst_n,
  smb_in_if.sink   in_ch,
  smb_out_if.source out_ch
);
  import smb_pkg::*;

  store_ctl_t ctl;
  flags_t     used;
  slot_idx_t  last_slot;
  logic       last_valid;
  size_t      rd_size;
  word_t      rd_word;
  logic       found;
  logic       overwrote;
  logic       accept;

  logic       out_valid_r;
  logic       found_r;
  out_slot_t  slot_r;
  logic       overwrote_r;
  size_t      size_r;
  word_t      word_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  smb_scan u_scan (
    .used       (used),
    .last_slot  (last_slot),
    .last_valid (last_valid),
    .accept     (accept),
    .func       (in_ch.func),
    .ctl        (ctl),
    .found      (found),
    .overwrote  (overwrote)
  );

  smb_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .wr_size    (in_ch.msg_size),
    .wr_word    (in_ch.msg_word),
    .used       (used),
    .last_slot  (last_slot),
    .last_valid (last_valid),
    .rd_size    (rd_size),
    .rd_word    (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_r     <= found;
      overwrote_r <= overwrote;
      if (in_ch.func == FUNC_POP && found) begin
        slot_r <= out_slot_t'(ctl.idx);
        size_r <= rd_size;
        word_r <= rd_word;
      end else if (in_ch.func == FUNC_POP) begin
        slot_r <= '0;
        size_r <= '0;
        word_r <= '0;
      end else begin
        slot_r <= out_slot_t'(ctl.idx);
        size_r <= '0;
        word_r <= '0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.found     = found_r;
  assign out_ch.slot      = slot_r;
  assign out_ch.overwrote = overwrote_r;
  assign out_ch.out_size  = size_r;
  assign out_ch.out_word  = word_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("request not accepted while result register is empty");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> slot_r == '0 && size_r == '0 && word_r == '0)
    else $error("empty pop result carries nonzero fields");

  a_overwrite_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && overwrote_r |-> slot_r == '0 && found_r)
    else $error("overwrite reported for a slot other than zero");

  a_full_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.func == FUNC_APPEND && used == '1 |=> overwrote_r)
    else $error("append to a full store did not report an overwrite");

  a_no_wr_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.wr_en && ctl.clr_en))
    else $error("store write and clear in the same cycle");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench of the slot message buffer with random stimulus and flow control.
module testbench;
  import smb_pkg::*;

  typedef struct packed {
    logic      found;
    out_slot_t slot;
    logic      overwrote;
    size_t     out_size;
    word_t     out_word;
  } slot_result_t;

  logic clk;
  logic rst_n;

  smb_in_if  in_ch();
  smb_out_if out_ch();

  slot_message_buffer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  slot_result_t pending_results[$];
  int           error_count = 0;

  logic      slot_used[SLOTS];
  word_t     slot_word[SLOTS];
  size_t     slot_size[SLOTS];
  slot_idx_t pop_ptr = '0;
  logic      pop_ptr_valid = 1'b0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic slot_result_t predict_slot_result(logic f, size_t s, word_t w);
    slot_result_t r;
    int pick;
    int i;
    r = '0;
    pick = -1;
    if (f == FUNC_APPEND) begin
      for (i = 0; i < SLOTS; i++) begin
        if (!slot_used[i] && pick < 0) pick = i;
      end
      r.found = 1'b1;
      if (pick < 0) begin
        pick = 0;
        r.overwrote = 1'b1;
      end
      slot_used[pick] = 1'b1;
      slot_word[pick] = w;
      slot_size[pick] = s;
      r.slot = out_slot_t'(pick);
    end else begin
      if (pop_ptr_valid) begin
        for (i = int'(pop_ptr); i < SLOTS; i++) begin
          if (slot_used[i] && pick < 0) pick = i;
        end
      end
      if (pick < 0) begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && pick < 0) pick = i;
        end
      end
      if (pick < 0) begin
        pop_ptr_valid = 1'b0;
        pop_ptr = '0;
      end else begin
        slot_used[pick] = 1'b0;
        r.found = 1'b1;
        r.slot = out_slot_t'(pick);
        r.out_size = slot_size[pick];
        r.out_word = slot_word[pick];
        slot_size[pick] = '0;
        pop_ptr = slot_idx_t'(pick);
        pop_ptr_valid = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    slot_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 64'(out_ch.slot), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.found !== want.found)
          report_mismatch("found", 64'(out_ch.found), 64'(want.found));
        if (out_ch.slot !== want.slot)
          report_mismatch("slot", 64'(out_ch.slot), 64'(want.slot));
        if (out_ch.overwrote !== want.overwrote)
          report_mismatch("overwrote", 64'(out_ch.overwrote), 64'(want.overwrote));
        if (out_ch.out_size !== want.out_size)
          report_mismatch("out_size", 64'(out_ch.out_size), 64'(want.out_size));
        if (out_ch.out_word !== want.out_word)
          report_mismatch("out_word", out_ch.out_word, want.out_word);
      end
    end
  end

  // The result side stalls in random bursts, or for a long hold when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic f, input size_t s, input word_t w);
    int  gap;
    bit  accepted;
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.msg_size <= s;
    in_ch.msg_word <= w;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk);
      accepted = (in_ch.ready === 1'b1);
      if (!accepted) @(negedge clk);
    end
    pending_results.push_back(predict_slot_result(f, s, w));
  endtask

  task automatic send_random(input int append_pct);
    logic  f;
    size_t s;
    word_t w;
    f = ($urandom_range(0, 99) < append_pct) ? FUNC_APPEND : FUNC_POP;
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = '1;
      default: s = size_t'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      default: w = {$urandom, $urandom};
    endcase
    send_request(f, s, w);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int i;
    send_request(FUNC_POP, '0, '0);
    send_request(FUNC_APPEND, '0, '0);
    send_request(FUNC_APPEND, '1, '1);
    send_request(FUNC_POP, '0, '0);
    send_request(FUNC_POP, '1, '1);
    send_request(FUNC_POP, '0, '0);
    for (i = 0; i < SLOTS; i++) begin
      send_request(FUNC_APPEND, size_t'(i * 17), {32'hA5A5_0000 | i, ~32'(i)});
    end
    send_request(FUNC_APPEND, 8'h5A, 64'hDEAD_BEEF_0123_4567);
    send_request(FUNC_POP, '0, '0);
    send_request(FUNC_POP, '0, '0);
    wait_drain();
  endtask

  task automatic test_random_mixed();
    int i;
    int pct;
    pct = 50;
    for (i = 0; i < 800; i++) begin
      if (i % 50 == 0) pct = $urandom_range(20, 80);
      send_random(pct);
    end
  endtask

  task automatic test_fill_drain();
    int sent;
    int k;
    sent = 0;
    while (sent < 700) begin
      for (k = $urandom_range(1, 20); k > 0; k--) begin
        send_random(100);
        sent++;
      end
      for (k = $urandom_range(1, 20); k > 0; k--) begin
        send_random(0);
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    int i;
    hold_left = 150;
    for (i = 0; i < 20; i++) send_random(60);
    wait_drain();
    for (i = 0; i < 20; i++) send_random(40);
    wait_drain();
  endtask

  task automatic test_steady_stream();
    int i;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (i = 0; i < 300; i++) send_random(50);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_word[i] = '0;
      slot_size[i] = '0;
    end
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_APPEND;
    in_ch.msg_size = '0;
    in_ch.msg_word = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mixed();
    test_fill_drain();
    test_backpressure();
    test_steady_stream();

    wait_drain();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/smb_pkg.sv
hdl/smb_if.sv
hdl/smb_scan.sv
hdl/smb_store.sv
hdl/slot_message_buffer.sv
bench/testbench.sv
